FILE: rtl/core/assert_macros.svh
// assertion macros shared by the transcoder rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property check, disabled during reset
`define U2U_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, consequent in the cycle after the antecedent
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define U2U_ASSERT(lbl, clk, rst_n, prop, msg)
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/u2u_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
// no dependencies
package u2u_pkg;

  localparam logic [15:0] QMark   = 16'h003F;
  localparam logic [15:0] HiSurr  = 16'hD800;
  localparam logic [15:0] LoSurr  = 16'hDC00;
  localparam logic [20:0] Plane1  = 21'h010000;

  // sequence lengths held in the decode state
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqTwo  = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour = 3'd4;

  // one queued command: qmark_cnt '?' units, then tail_cnt tail units
  typedef struct packed {
    logic [2:0]  qmark_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        eos;
  } cmd_t;

endpackage

FILE: rtl/core/utf8_to_utf16_transcoder_core.sv
// utf8_to_utf16_transcoder_core: utf-8 bytes in, utf-16 code units out
// depends on u2u_pkg, u2u_front, u2u_fifo, u2u_back and assert_macros.svh
//
// input side is a queue: drive data_byte_i / end_of_string_i and raise push;
// the byte is taken at a clock edge where push is high and full is low
// result side is a queue too: while empty is low the oldest code unit sits on
// code_unit_o, last_of_run_o, string_done_o; pop takes it
// the first unit of a byte passes the command queue (written at the taking
// edge) and then the output register, which loads once it is empty or popped
// throughput: one byte per cycle in while full is low, one code unit per
// cycle out while pop is high; the single output register sets the output
// rate, so bytes that give several units (surrogate pairs, flushed
// sequences, up to four units) drain through it while the QueueDepth-entry
// command queue absorbs the burst; bytes that complete nothing (held leads,
// inner continuation bytes) put nothing in the queue
// a stalled receiver (pop low) holds the output unit; the queue fills and
// full rises, the decoder state stays put until push is taken again
// reset clears the decode state and the queue and empties the output register
module utf8_to_utf16_transcoder_core #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o,
  output logic        string_done_o
);

  `include "assert_macros.svh"

  localparam int CntW = $clog2(QueueDepth + 1);

  logic                accept;
  logic                cmd_valid;
  u2u_pkg::cmd_t       cmd;
  u2u_pkg::cmd_t       q_head;
  logic                q_full, q_empty, q_rd;
  logic [CntW-1:0]     q_level;

  // a byte is taken whenever the queue has room, even if the output waits
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: classify byte, update sequence state, build a command
  u2u_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  // commands waiting for the back end
  u2u_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .rd_i      (q_rd),
    .rd_data_o (q_head),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .level_o   (q_level)
  );

  // back: one code unit per cycle into the output register when free or popped
  u2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .code_unit_o   (code_unit_o),
    .last_of_run_o (last_of_run_o),
    .string_done_o (string_done_o)
  );

  // end of string is only flagged on the last unit of a byte
  `U2U_ASSERT(a_done_is_last, clk_i, rst_ni, empty || !string_done_o || last_of_run_o, "string_done without last_of_run")

  // queue occupancy stays within its depth
  `U2U_ASSERT(a_level_bound, clk_i, rst_ni, q_level <= CntW'(QueueDepth), "command queue over depth")

  // with nothing queued or arriving, taking a last unit leaves the output empty
  `U2U_ASSERT_NEXT(a_drain, clk_i, rst_ni, !empty && pop && last_of_run_o && q_empty && !cmd_valid, empty, "unit appeared from an empty queue")

  // a command read only happens on a byte's last unit into the output register
  `U2U_ASSERT_NEXT(a_rd_marks_last, clk_i, rst_ni, q_rd, !empty && last_of_run_o, "queue read without last unit")

endmodule

FILE: rtl/core/u2u_front.sv
// front end: byte classification, decode state and command building
// depends on u2u_pkg
module u2u_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_string_i,
  output logic          cmd_valid_o,
  output u2u_pkg::cmd_t cmd_o
);

  logic [2:0]  seq_len_q, seq_len_d;
  logic [1:0]  seen_q, seen_d;
  logic [20:0] cp_q, cp_d;

  logic        is_cont;
  logic        fresh;
  logic [1:0]  seen_inc;
  logic [20:0] cp_shift;
  logic [20:0] cp_off;
  logic [2:0]  total;

  assign is_cont  = (data_byte_i[7:6] == 2'b10);
  assign seen_inc = seen_q + 2'd1;
  assign cp_shift = {cp_q[14:0], data_byte_i[5:0]};
  assign cp_off   = cp_shift - u2u_pkg::Plane1;

  always_comb begin
    seq_len_d = seq_len_q;
    seen_d    = seen_q;
    cp_d      = cp_q;
    fresh     = 1'b1;
    cmd_o     = '0;
    cmd_o.eos = end_of_string_i;

    if (seq_len_q != u2u_pkg::SeqNone) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (({1'b0, seen_inc} + 3'd1) >= seq_len_q) begin
          // sequence complete
          if (cp_shift < u2u_pkg::Plane1) begin
            cmd_o.tail_cnt = 2'd1;
            cmd_o.unit0    = cp_shift[15:0];
          end else begin
            cmd_o.tail_cnt = 2'd2;
            cmd_o.unit0    = u2u_pkg::HiSurr + {5'd0, cp_off[20:10]};
            cmd_o.unit1    = u2u_pkg::LoSurr + {6'd0, cp_off[9:0]};
          end
          seq_len_d = u2u_pkg::SeqNone;
          seen_d    = '0;
          cp_d      = '0;
        end else if (end_of_string_i) begin
          cmd_o.qmark_cnt = {1'b0, seen_inc} + 3'd1;
          seq_len_d = u2u_pkg::SeqNone;
          seen_d    = '0;
          cp_d      = '0;
        end else begin
          seen_d = seen_inc;
          cp_d   = cp_shift;
        end
      end else begin
        // broken sequence
        cmd_o.qmark_cnt = {1'b0, seen_q} + 3'd1;
        seq_len_d = u2u_pkg::SeqNone;
        seen_d    = '0;
        cp_d      = '0;
      end
    end

    if (fresh) begin
      if (!data_byte_i[7]) begin
        cmd_o.tail_cnt = 2'd1;
        cmd_o.unit0    = {8'd0, data_byte_i};
      end else if (is_cont || (data_byte_i[7:3] == 5'b11111)) begin
        cmd_o.qmark_cnt = cmd_o.qmark_cnt + 3'd1;
      end else begin
        seen_d = '0;
        if (data_byte_i[7:5] == 3'b110) begin
          seq_len_d = u2u_pkg::SeqTwo;
          cp_d      = {16'd0, data_byte_i[4:0]};
        end else if (data_byte_i[7:4] == 4'b1110) begin
          seq_len_d = u2u_pkg::SeqThree;
          cp_d      = {17'd0, data_byte_i[3:0]};
        end else begin
          seq_len_d = u2u_pkg::SeqFour;
          cp_d      = {18'd0, data_byte_i[2:0]};
        end
        if (end_of_string_i) begin
          // lone lead at end of string
          cmd_o.qmark_cnt = cmd_o.qmark_cnt + 3'd1;
          seq_len_d = u2u_pkg::SeqNone;
          cp_d      = '0;
        end
      end
    end
  end

  assign total       = cmd_o.qmark_cnt + {1'b0, cmd_o.tail_cnt};
  assign cmd_valid_o = accept_i && (total != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= u2u_pkg::SeqNone;
      seen_q    <= '0;
      cp_q      <= '0;
    end else if (accept_i) begin
      seq_len_q <= seq_len_d;
      seen_q    <= seen_d;
      cp_q      <= cp_d;
    end
  end

endmodule

FILE: rtl/core/u2u_fifo.sv
// command queue between front and back end
// depends on u2u_pkg
module u2u_fifo #(
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  u2u_pkg::cmd_t              wr_data_i,
  input  logic                       rd_i,
  output u2u_pkg::cmd_t              rd_data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u2u_pkg::cmd_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign level_o   = cnt_q;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/u2u_back.sv
// back end: expands queued commands into code units, one per cycle
// while its output register is free or popped; depends on u2u_pkg
module u2u_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  u2u_pkg::cmd_t q_head_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [15:0]   code_unit_o,
  output logic          last_of_run_o,
  output logic          string_done_o
);

  logic        valid_q;
  logic [1:0]  idx_q;
  logic [15:0] unit_q;
  logic        last_q, done_q;

  logic        load;
  logic [2:0]  total;
  logic [2:0]  tail_idx;
  logic        is_last;
  logic [15:0] unit_sel;

  assign load     = !q_empty_i && (!valid_q || pop_i);
  assign total    = q_head_i.qmark_cnt + {1'b0, q_head_i.tail_cnt};
  assign is_last  = (({1'b0, idx_q} + 3'd1) == total);
  assign tail_idx = {1'b0, idx_q} - q_head_i.qmark_cnt;
  assign q_rd_o   = load && is_last;

  always_comb begin
    if ({1'b0, idx_q} < q_head_i.qmark_cnt) begin
      unit_sel = u2u_pkg::QMark;
    end else if (tail_idx == 3'd0) begin
      unit_sel = q_head_i.unit0;
    end else begin
      unit_sel = q_head_i.unit1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= unit_sel;
      last_q <= is_last;
      done_q <= is_last && q_head_i.eos;
    end
  end

  assign empty_o       = !valid_q;
  assign code_unit_o   = unit_q;
  assign last_of_run_o = last_q;
  assign string_done_o = done_q;

endmodule

FILE: verif/tb_utf8_to_utf16_transcoder_core.sv
// testbench for utf8_to_utf16_transcoder_core: directed and random utf-8 strings
// depends on u2u_pkg and the transcoder rtl; a scoreboard class predicts the units
module tb_utf8_to_utf16_transcoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound: ~310 items, up to four units each, random stalls and gaps
  localparam int CycleLimit = 200000;
  // items after which neither side idles any more
  localparam int QuietAfter = 260;
  // random part starts no new string once this many items have been taken
  localparam int ItemTarget = 295;

  // one expected utf-16 unit with its flags
  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        done;
  } utf16_unit_t;

  // decoder state mirror plus the queue of units still owed by the block
  class utf16_scoreboard;
    logic [2:0]  seq_len;
    logic [1:0]  conts_held;
    logic [20:0] partial_cp;
    logic [15:0] step_units[$];
    utf16_unit_t expected_q[$];
    int          err_count;

    function new();
      clear_seq();
      err_count = 0;
    endfunction

    function void clear_seq();
      seq_len    = u2u_pkg::SeqNone;
      conts_held = 2'd0;
      partial_cp = 21'd0;
    endfunction

    // one byte never gives more than four units
    function void add_unit(logic [15:0] u);
      if (step_units.size() < 4) step_units.push_back(u);
    endfunction

    // code point to one unit or a surrogate pair
    function void add_codepoint(logic [20:0] cp);
      logic [20:0] v;
      if (cp < u2u_pkg::Plane1) begin
        add_unit(cp[15:0]);
      end else begin
        v = cp - u2u_pkg::Plane1;
        add_unit(u2u_pkg::HiSurr + {5'd0, v[20:10]});
        add_unit(u2u_pkg::LoSurr + {6'd0, v[9:0]});
      end
    endfunction

    // pending sequence becomes '?' for the lead and each held continuation
    function void flush_seq();
      for (int i = 0; i <= int'(conts_held); i++) add_unit(u2u_pkg::QMark);
      clear_seq();
    endfunction

    // accepted byte: advance the decoder and queue what it gives
    function void note_byte(logic [7:0] b, logic eos);
      logic        is_cont;
      logic        fresh;
      utf16_unit_t u;
      is_cont = (b[7:6] == 2'b10);
      fresh   = 1'b1;
      step_units.delete();
      if (seq_len != u2u_pkg::SeqNone) begin
        if (is_cont) begin
          fresh      = 1'b0;
          partial_cp = {partial_cp[14:0], b[5:0]};
          conts_held = conts_held + 2'd1;
          if (int'(conts_held) + 1 >= int'(seq_len)) begin
            add_codepoint(partial_cp);
            clear_seq();
          end else if (eos) begin
            flush_seq();
          end
        end else begin
          flush_seq();
        end
      end
      if (fresh) begin
        if (b < 8'h80) begin
          add_unit({8'h00, b});
        end else if (is_cont || b >= 8'hF8) begin
          add_unit(u2u_pkg::QMark);
        end else begin
          if (b < 8'hE0) begin
            seq_len    = u2u_pkg::SeqTwo;
            partial_cp = {16'd0, b[4:0]};
          end else if (b < 8'hF0) begin
            seq_len    = u2u_pkg::SeqThree;
            partial_cp = {17'd0, b[3:0]};
          end else begin
            seq_len    = u2u_pkg::SeqFour;
            partial_cp = {18'd0, b[2:0]};
          end
          conts_held = 2'd0;
          if (eos) flush_seq();
        end
      end
      foreach (step_units[k]) begin
        u.code = step_units[k];
        u.last = (k == step_units.size() - 1);
        u.done = u.last && eos;
        expected_q.push_back(u);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      err_count++;
    endtask

    // accepted unit against the oldest expectation
    task check_unit(logic [15:0] code, logic last, logic done);
      utf16_unit_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unit %h arrived with nothing expected", code));
      end else begin
        e = expected_q.pop_front();
        if (code !== e.code)
          report($sformatf("code_unit %h, expected %h", code, e.code));
        if (last !== e.last)
          report($sformatf("last_of_run %b, expected %b (unit %h)", last, e.last, e.code));
        if (done !== e.done)
          report($sformatf("string_done %b, expected %b (unit %h)", done, e.done, e.code));
      end
    endtask
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        push            = 1'b0;
  logic        pop             = 1'b0;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        end_of_string_i = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] code_unit_o;
  logic        last_of_run_o;
  logic        string_done_o;

  utf16_scoreboard sb;
  int items_sent  = 0;
  int cycle_count = 0;
  // true in the last part of the run: no gaps, no stalls
  logic quiet;
  assign quiet = (items_sent >= QuietAfter);

  utf8_to_utf16_transcoder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .empty          (empty),
    .pop            (pop),
    .code_unit_o    (code_unit_o),
    .last_of_run_o  (last_of_run_o),
    .string_done_o  (string_done_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL utf8_to_utf16_transcoder_core");
      $finish;
    end
  end

  // both handshakes sampled at the rising edge; inputs only move at the falling edge,
  // so pre-edge values of full/empty are seen here without any race
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_byte(data_byte_i, end_of_string_i);
    if (rst_ni && pop && !empty) sb.check_unit(code_unit_o, last_of_run_o, string_done_o);
  end

  // receiver: pop mostly high, with random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        // this cycle is the first of the burst
        stall_left = $urandom_range(1, 8) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one item: optional gap, then hold push until the block takes the byte;
  // entered and left at a falling edge, so push changes once per step
  task send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push            <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] trail_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // lead byte of a 2, 3 or 4 byte sequence with random payload bits
  function automatic logic [7:0] lead_byte(int len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // a string of 1 to 10 characters, mostly well formed; last byte carries eos
  task send_random_string();
    logic [7:0] str_q[$];
    int         n_chars;
    int         sel;
    int         len;
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        str_q.push_back(8'($urandom_range(0, 127)));
      end else if (sel < 72) begin
        // complete sequence with random content
        len = (sel < 45) ? 2 : (sel < 60) ? 3 : 4;
        str_q.push_back(lead_byte(len));
        repeat (len - 1) str_q.push_back(trail_byte());
      end else if (sel < 82) begin
        // truncated: broken by the next character or by the end of the string
        len = $urandom_range(2, 4);
        str_q.push_back(lead_byte(len));
        repeat ($urandom_range(0, len - 2)) str_q.push_back(trail_byte());
      end else if (sel < 92) begin
        // stray continuation or invalid lead
        if ($urandom_range(0, 1)) str_q.push_back(trail_byte());
        else str_q.push_back(8'($urandom_range(248, 255)));
      end else begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ascii extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // largest two-byte form
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
    // surrogate code point passes through
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    // first code point that needs a surrogate pair
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // above 0x10FFFF, same pair arithmetic
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // bad leads: lone continuation, invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    // overlong lead broken by 0xFF: two question marks
    send_byte(8'hC0, 1'b0); send_byte(8'hFF, 1'b0);
    // three held bytes broken by ascii: four units from one byte
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    // string ends inside a sequence, then on a lone lead
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b1);
    send_byte(8'hC3, 1'b1);

    while (items_sent < ItemTarget) send_random_string();
    push <= 1'b0;

    // drain, then keep watching for any stray unit
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.err_count == 0) begin
      $display("PASS utf8_to_utf16_transcoder_core");
    end else begin
      $display("FAIL utf8_to_utf16_transcoder_core");
    end
    $finish;
  end

endmodule
